// ===== rtl/core/sacl_pkg.sv =====
// Shared types, geometry constants and helper functions of the cache lookup block.
`default_nettype none
package sacl_pkg;

  // Geometry limits of the storage
  localparam int MAX_WAYS    = 8;
  localparam int MAX_SETS    = 512;
  localparam int ADDR_W      = 32;
  localparam int SET_W       = $clog2(MAX_SETS);
  localparam int WAY_W       = $clog2(MAX_WAYS);
  localparam int RANK_W      = WAY_W;
  localparam int FILL_W      = $clog2(MAX_WAYS + 1);
  localparam int CFG_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [CFG_W-1:0] offset_bits;
    logic [CFG_W-1:0] set_bits;
    logic [CFG_W-1:0] ways_used;
  } cfg_t;

  // One classified access waiting for the lookup engine
  typedef struct packed {
    logic [SET_W-1:0]  set_idx;
    logic [ADDR_W-1:0] tag;
  } item_t;

  // One set of the line store: tags, recency ranks and fill count
  typedef struct packed {
    logic [MAX_WAYS-1:0][ADDR_W-1:0] tag;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    logic [FILL_W-1:0]               fill;
  } row_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  // Set bits in use, limited to what the store holds
  function automatic logic [CFG_W-1:0] eff_set_bits(input logic [CFG_W-1:0] s);
    logic [CFG_W-1:0] r;
    r = s;
    if (s > CFG_W'(SET_W)) r = CFG_W'(SET_W);
    return r;
  endfunction

  // Associativity in use, clamped to 1..MAX_WAYS
  function automatic logic [FILL_W-1:0] eff_ways(input logic [CFG_W-1:0] w);
    logic [FILL_W-1:0] r;
    r = FILL_W'(w);
    if (w == '0) r = FILL_W'(1);
    if (w > CFG_W'(MAX_WAYS)) r = FILL_W'(MAX_WAYS);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sacl_queue.sv =====
// Short queue of classified accesses between the front end and the lookup engine.
`default_nettype none
module sacl_queue (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire sacl_pkg::item_t         push_item,
  input  wire logic                    pop,
  output sacl_pkg::item_t              head_item,
  output sacl_pkg::queue_status_t      status
);
  import sacl_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        if (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) wr_ptr <= '0;
        else wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        if (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) rd_ptr <= '0;
        else rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assign head_item    = entries[rd_ptr];
  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule
`default_nettype wire

// ===== rtl/core/sacl_front.sv =====
// Front end: takes access commands and splits each address into set index and tag.
`default_nettype none
module sacl_front (
  input  wire logic                      start,
  input  wire logic [sacl_pkg::ADDR_W-1:0] address,
  input  wire sacl_pkg::cfg_t            cfg,
  input  wire sacl_pkg::queue_status_t   q_status,
  input  wire sacl_pkg::back_status_t    b_status,
  output logic                           busy,
  output logic                           push,
  output sacl_pkg::item_t                item
);
  import sacl_pkg::*;

  logic [CFG_W-1:0]  sb;
  logic [CFG_W:0]    tag_shift;
  logic [ADDR_W-1:0] above_offset;
  logic [SET_W-1:0]  set_mask;

  // hold off while the queue is full or the store is being cleared
  assign busy = q_status.full || b_status.clearing;
  assign push = start && !busy;

  // address split
  always_comb begin
    sb           = eff_set_bits(cfg.set_bits);
    tag_shift    = {1'b0, cfg.offset_bits} + {1'b0, sb};
    above_offset = address >> cfg.offset_bits;
    set_mask     = ~({SET_W{1'b1}} << sb);
    item.set_idx = above_offset[SET_W-1:0] & set_mask;
    item.tag     = address >> tag_shift;
  end

endmodule
`default_nettype wire

// ===== rtl/core/sacl_back.sv =====
// Lookup engine: reads one set, resolves hit or victim, updates recency and totals.
`default_nettype none
module sacl_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire sacl_pkg::cfg_t            cfg,
  input  wire sacl_pkg::item_t           head_item,
  input  wire sacl_pkg::queue_status_t   q_status,
  output logic                           pop,
  output sacl_pkg::back_status_t         status,
  output logic                           done,
  output logic                           hit,
  output logic [sacl_pkg::WAY_W-1:0]     way_used,
  output logic                           evicted,
  output logic [31:0]                    hit_total,
  output logic [31:0]                    miss_total
);
  import sacl_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

  state_t            state;
  logic [SET_W-1:0]  clr_idx;
  item_t             cur;
  row_t              store [MAX_SETS];
  row_t              rd_row;
  row_t              row_new;
  logic              mem_we;
  logic [SET_W-1:0]  mem_waddr;
  row_t              mem_wdata;

  logic [FILL_W-1:0] n;
  logic [FILL_W-1:0] nw;
  logic              hit_any;
  logic [WAY_W-1:0]  hit_way;
  logic [RANK_W-1:0] best;
  logic [WAY_W-1:0]  lru_way;
  logic              fill;
  logic [WAY_W-1:0]  way_sel;
  logic [RANK_W-1:0] old_rank;

  assign pop             = (state == ST_IDLE) && !q_status.empty;
  assign status.clearing = (state == ST_CLEAR);

  // line store: one row per set, registered read
  assign mem_we    = (state == ST_CLEAR) || (state == ST_LOOKUP);
  assign mem_waddr = (state == ST_CLEAR) ? clr_idx : cur.set_idx;
  assign mem_wdata = (state == ST_CLEAR) ? row_t'('0) : row_new;

  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= mem_wdata;
    rd_row <= store[head_item.set_idx];
  end

  // hit detection, victim choice and recency update for the set just read
  always_comb begin
    n = rd_row.fill;
    if (n > FILL_W'(MAX_WAYS)) n = FILL_W'(MAX_WAYS);
    nw = eff_ways(cfg.ways_used);

    // first matching way wins
    hit_any = 1'b0;
    hit_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (i < n && rd_row.tag[i] == cur.tag) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(i);
      end
    end

    // oldest filled way, last one on a tie
    best    = '0;
    lru_way = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i < n && rd_row.rank[i] >= best) begin
        best    = rd_row.rank[i];
        lru_way = WAY_W'(i);
      end
    end

    fill = !hit_any && (n < nw);
    if (hit_any) way_sel = hit_way;
    else if (fill) way_sel = n[WAY_W-1:0];
    else way_sel = lru_way;
    old_rank = rd_row.rank[way_sel];

    // newer ways than the touched one age by one; a fill ages all filled ways
    row_new = rd_row;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i < n && WAY_W'(i) != way_sel && (fill || rd_row.rank[i] < old_rank)) begin
        row_new.rank[i] = rd_row.rank[i] + 1'b1;
      end
    end
    row_new.rank[way_sel] = '0;
    if (!hit_any) row_new.tag[way_sel] = cur.tag;
    if (fill) row_new.fill = n + 1'b1;
  end

  // sequencer, totals and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      done       <= 1'b0;
      hit_total  <= '0;
      miss_total <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SET_W'(MAX_SETS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (!q_status.empty) state <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          state <= ST_IDLE;
          done  <= 1'b1;
          if (hit_any) hit_total <= hit_total + 1'b1;
          else miss_total <= miss_total + 1'b1;
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // captured access and result beat payload
  always_ff @(posedge clk) begin
    if (pop) cur <= head_item;
    if (state == ST_LOOKUP) begin
      hit      <= hit_any;
      way_used <= way_sel;
      evicted  <= !hit_any && !fill;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/set_assoc_cache_lru_lookup.sv =====
// Top level of the set-associative cache lookup with LRU replacement.
//
//  channel   handshake                  payload
//  --------  -------------------------  ------------------------------------------
//  access    start / busy               address
//  result    done (one-cycle strobe)    hit, way_used, evicted, hit_total, miss_total
//  config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  An access passes through the lookup engine in order: its set row is read from the
//  line store into a register, then hit or victim is resolved and the row written back;
//  the result beat follows in the next cycle. The engine takes a new access only once
//  the last one is resolved. A two-beat queue sits between the front end and the lookup
//  engine; busy rises when it is full. After reset a clearing pass zeroes the fill counts
//  of all 512 sets, with busy high; configuration writes are taken throughout.
`default_nettype none
module set_assoc_cache_lru_lookup (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [3:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire logic                        start,
  input  wire logic [sacl_pkg::ADDR_W-1:0] address,
  output logic                             busy,
  output logic                             done,
  output logic                             hit,
  output logic [sacl_pkg::WAY_W-1:0]       way_used,
  output logic                             evicted,
  output logic [31:0]                      hit_total,
  output logic [31:0]                      miss_total
);
  import sacl_pkg::*;

  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_SET_BITS    = 2'd1;
  localparam logic [1:0] REG_WAYS_USED   = 2'd2;

  cfg_t          cfg;
  logic          cfg_we;
  logic          push;
  item_t         push_item;
  item_t         head_item;
  logic          pop;
  queue_status_t q_status;
  back_status_t  b_status;

  // register file
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_bits <= CFG_W'(6);
      cfg.set_bits    <= CFG_W'(4);
      cfg.ways_used   <= CFG_W'(1);
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_OFFSET_BITS: cfg.offset_bits <= pwdata[CFG_W-1:0];
        REG_SET_BITS:    cfg.set_bits    <= pwdata[CFG_W-1:0];
        REG_WAYS_USED:   cfg.ways_used   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_OFFSET_BITS: prdata = 32'(cfg.offset_bits);
      REG_SET_BITS:    prdata = 32'(cfg.set_bits);
      REG_WAYS_USED:   prdata = 32'(cfg.ways_used);
      default:         prdata = '0;
    endcase
  end

  sacl_front u_front (
    .start    (start),
    .address  (address),
    .cfg      (cfg),
    .q_status (q_status),
    .b_status (b_status),
    .busy     (busy),
    .push     (push),
    .item     (push_item)
  );

  sacl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_status)
  );

  sacl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_item  (head_item),
    .q_status   (q_status),
    .pop        (pop),
    .status     (b_status),
    .done       (done),
    .hit        (hit),
    .way_used   (way_used),
    .evicted    (evicted),
    .hit_total  (hit_total),
    .miss_total (miss_total)
  );

endmodule
`default_nettype wire
